@@ hw/rtl/tcf_pkg.sv @@
package tcf_pkg;

   // Field widths
   localparam int RAW_W      = 12;
   localparam int PRESS_W    = 8;
   localparam int POS_X_W    = 8;
   localparam int POS_Y_W    = 9;
   localparam int OFFSET_W   = 13;
   localparam int MOVE_THR_W = 10;

   // Register file
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 13;

   localparam logic [CSR_IDX_W-1:0] REG_X_SPLIT        = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_X_OFFSET_LOW   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_X_OFFSET_HIGH  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_Y_OFFSET       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_MOVE_THRESHOLD = 3'd4;

   localparam logic [RAW_W-1:0]      X_SPLIT_RST        = 12'd3000;
   localparam logic [OFFSET_W-1:0]   X_OFFSET_LOW_RST   = 13'd3870;
   localparam logic [OFFSET_W-1:0]   X_OFFSET_HIGH_RST  = 13'd3800;
   localparam logic [RAW_W-1:0]      Y_OFFSET_RST       = 12'd360;
   localparam logic [MOVE_THR_W-1:0] MOVE_THRESHOLD_RST = 10'd5;

   // Screen size defaults
   localparam int SCREEN_WIDTH_DEF  = 240;
   localparam int SCREEN_HEIGHT_DEF = 320;

   // Constant division by reciprocal multiply; exact for any 13-bit dividend.
   //   x / 15 = (x * 8739) >> 17
   //   y / 11 = (y * 5958) >> 16
   localparam int DIFF_W  = 13;
   localparam int RECIP_W = 14;
   localparam int QUOT_W  = 10;
   localparam int X_RECIP = 8739;
   localparam int X_SHIFT = 17;
   localparam int Y_RECIP = 5958;
   localparam int Y_SHIFT = 16;

   typedef struct packed {
      logic [RAW_W-1:0]      x_split;
      logic [OFFSET_W-1:0]   x_offset_low;
      logic [OFFSET_W-1:0]   x_offset_high;
      logic [RAW_W-1:0]      y_offset;
      logic [MOVE_THR_W-1:0] move_threshold;
   } cfg_type;

endpackage

@@ hw/rtl/tcf_csr.sv @@
module tcf_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [tcf_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [tcf_pkg::CSR_DATA_W-1:0]   csr_data,
   output tcf_pkg::cfg_type                 cfg
);
   import tcf_pkg::*;

   cfg_type cfg_ff;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.x_split        <= X_SPLIT_RST;
         cfg_ff.x_offset_low   <= X_OFFSET_LOW_RST;
         cfg_ff.x_offset_high  <= X_OFFSET_HIGH_RST;
         cfg_ff.y_offset       <= Y_OFFSET_RST;
         cfg_ff.move_threshold <= MOVE_THRESHOLD_RST;
      end else if (csr_valid) begin
         case (csr_index)
            REG_X_SPLIT:        cfg_ff.x_split        <= csr_data[RAW_W-1:0];
            REG_X_OFFSET_LOW:   cfg_ff.x_offset_low   <= csr_data[OFFSET_W-1:0];
            REG_X_OFFSET_HIGH:  cfg_ff.x_offset_high  <= csr_data[OFFSET_W-1:0];
            REG_Y_OFFSET:       cfg_ff.y_offset       <= csr_data[RAW_W-1:0];
            REG_MOVE_THRESHOLD: cfg_ff.move_threshold <= csr_data[MOVE_THR_W-1:0];
            default: ;  // unmapped index, dropped
         endcase
      end
   end

endmodule

@@ hw/rtl/tcf_scale.sv @@
// (base - sub) / divisor, zero when not positive, clamped to LIMIT-1.
module tcf_scale #(
   parameter int RECIP = tcf_pkg::X_RECIP,
   parameter int SHIFT = tcf_pkg::X_SHIFT,
   parameter int LIMIT = tcf_pkg::SCREEN_WIDTH_DEF
) (
   input  logic [tcf_pkg::DIFF_W-1:0] base,
   input  logic [tcf_pkg::DIFF_W-1:0] sub,
   output logic [$clog2(LIMIT)-1:0]   quot
);
   import tcf_pkg::*;

   localparam int Q_W    = $clog2(LIMIT);
   localparam int PROD_W = DIFF_W + RECIP_W;
   localparam logic [QUOT_W:0] LIMIT_M1 = (QUOT_W+1)'(LIMIT - 1);

   logic [DIFF_W-1:0] diff;
   logic [PROD_W-1:0] prod;
   logic [QUOT_W-1:0] raw_quot;

   assign diff     = base - sub;
   assign prod     = PROD_W'(diff) * PROD_W'(RECIP);
   assign raw_quot = prod[SHIFT +: QUOT_W];

   always_comb begin
      if (base <= sub) begin
         quot = '0;
      end else if ({1'b0, raw_quot} > LIMIT_M1) begin
         quot = Q_W'(LIMIT_M1);
      end else begin
         quot = Q_W'(raw_quot);
      end
   end

endmodule

@@ hw/rtl/tcf_track.sv @@
// Held position with movement deadband; cleared when the touch goes away.
module tcf_track #(
   parameter int SCREEN_WIDTH  = tcf_pkg::SCREEN_WIDTH_DEF,
   parameter int SCREEN_HEIGHT = tcf_pkg::SCREEN_HEIGHT_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                step,
   input  logic                                touch,
   input  logic [$clog2(SCREEN_WIDTH)-1:0]     new_x,
   input  logic [$clog2(SCREEN_HEIGHT)-1:0]    new_y,
   input  logic [tcf_pkg::MOVE_THR_W-1:0]      move_threshold,
   output logic [$clog2(SCREEN_WIDTH)-1:0]     held_x_in,
   output logic [$clog2(SCREEN_HEIGHT)-1:0]    held_y_in
);
   import tcf_pkg::*;

   localparam int HX_W  = $clog2(SCREEN_WIDTH);
   localparam int HY_W  = $clog2(SCREEN_HEIGHT);
   localparam int AX_W  = (HX_W > HY_W) ? HX_W : HY_W;
   localparam int SUM_W = ((AX_W > MOVE_THR_W) ? AX_W : MOVE_THR_W) + 1;

   logic [HX_W-1:0]  held_x_ff;
   logic [HY_W-1:0]  held_y_ff;
   logic [HX_W-1:0]  dx;
   logic [HY_W-1:0]  dy;
   logic [SUM_W-1:0] move;
   logic             moved;

   assign dx    = (new_x > held_x_ff) ? new_x - held_x_ff : held_x_ff - new_x;
   assign dy    = (new_y > held_y_ff) ? new_y - held_y_ff : held_y_ff - new_y;
   assign move  = SUM_W'(dx) + SUM_W'(dy);
   assign moved = move > SUM_W'(move_threshold);

   always_comb begin
      if (!touch) begin
         held_x_in = '0;
         held_y_in = '0;
      end else if (moved) begin
         held_x_in = new_x;
         held_y_in = new_y;
      end else begin
         held_x_in = held_x_ff;
         held_y_in = held_y_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_x_ff <= '0;
         held_y_ff <= '0;
      end else if (step) begin
         held_x_ff <= held_x_in;
         held_y_ff <= held_y_in;
      end
   end

endmodule

@@ hw/rtl/touch_coordinate_filter_core.sv @@
// Touch coordinate filter: takes one touch-controller sample word per cycle
// (detect flag, raw 12-bit X/Y, pressure) while req_ready is high and returns
// one result word per sample with the calibrated, clamped and deadbanded
// screen position. X is subtracted from x_offset_low or x_offset_high (chosen
// by x_split) and divided by 15; Y has y_offset removed and is divided by 11;
// both clamp to the screen size minus one. The held position moves only when
// |dx|+|dy| exceeds move_threshold and is zeroed on a sample without touch;
// pressure passes through. A word passes through the input register and then
// the result register; throughput is one word per cycle while rsp_ready is
// high: the held-position register updates with each word that advances and
// the input and result registers let a new word enter while a result waits.
// Configuration writes are always accepted (csr_ready is tied high) and must
// be issued only while no sample is in flight; unmapped indexes are ignored.
module touch_coordinate_filter_core #(
   parameter int SCREEN_WIDTH  = tcf_pkg::SCREEN_WIDTH_DEF,
   parameter int SCREEN_HEIGHT = tcf_pkg::SCREEN_HEIGHT_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // sample input
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_touch_present,
   input  logic [tcf_pkg::RAW_W-1:0]         req_raw_x,
   input  logic [tcf_pkg::RAW_W-1:0]         req_raw_y,
   input  logic [tcf_pkg::PRESS_W-1:0]       req_raw_pressure,
   // result output
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_touched,
   output logic [tcf_pkg::POS_X_W-1:0]       rsp_pos_x,
   output logic [tcf_pkg::POS_Y_W-1:0]       rsp_pos_y,
   output logic [tcf_pkg::PRESS_W-1:0]       rsp_pressure,
   // register writes
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [tcf_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [tcf_pkg::CSR_DATA_W-1:0]    csr_data
);
   import tcf_pkg::*;

   localparam int HX_W = $clog2(SCREEN_WIDTH);
   localparam int HY_W = $clog2(SCREEN_HEIGHT);

   cfg_type cfg;

   // input register
   logic               in_valid_ff;
   logic               in_touch_ff;
   logic [RAW_W-1:0]   in_raw_x_ff;
   logic [RAW_W-1:0]   in_raw_y_ff;
   logic [PRESS_W-1:0] in_pressure_ff;

   // result register
   logic               rsp_valid_ff;
   logic               rsp_touched_ff;
   logic [POS_X_W-1:0] rsp_pos_x_ff;
   logic [POS_Y_W-1:0] rsp_pos_y_ff;
   logic [PRESS_W-1:0] rsp_pressure_ff;

   logic                advance;
   logic [OFFSET_W-1:0] x_base;
   logic [HX_W-1:0]     new_x;
   logic [HY_W-1:0]     new_y;
   logic [HX_W-1:0]     held_x_in;
   logic [HY_W-1:0]     held_y_in;

   tcf_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // word moves from input register to result register
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   // split point picks the X offset
   assign x_base = (in_raw_x_ff <= cfg.x_split) ? cfg.x_offset_low : cfg.x_offset_high;

   tcf_scale #(
      .RECIP (X_RECIP),
      .SHIFT (X_SHIFT),
      .LIMIT (SCREEN_WIDTH)
   ) u_scale_x (
      .base (x_base),
      .sub  (DIFF_W'(in_raw_x_ff)),
      .quot (new_x)
   );

   tcf_scale #(
      .RECIP (Y_RECIP),
      .SHIFT (Y_SHIFT),
      .LIMIT (SCREEN_HEIGHT)
   ) u_scale_y (
      .base (DIFF_W'(in_raw_y_ff)),
      .sub  (DIFF_W'(cfg.y_offset)),
      .quot (new_y)
   );

   tcf_track #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) u_track (
      .clock          (clock),
      .reset          (reset),
      .step           (advance),
      .touch          (in_touch_ff),
      .new_x          (new_x),
      .new_y          (new_y),
      .move_threshold (cfg.move_threshold),
      .held_x_in      (held_x_in),
      .held_y_in      (held_y_in)
   );

   // input register: control
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   // input register: payload
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_touch_ff    <= req_touch_present;
         in_raw_x_ff    <= req_raw_x;
         in_raw_y_ff    <= req_raw_y;
         in_pressure_ff <= req_raw_pressure;
      end
   end

   // result register: control
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // result register: payload; held values are cut or padded to field width
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_touched_ff  <= in_touch_ff;
         rsp_pos_x_ff    <= POS_X_W'(held_x_in);
         rsp_pos_y_ff    <= POS_Y_W'(held_y_in);
         rsp_pressure_ff <= in_pressure_ff;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_touched  = rsp_touched_ff;
   assign rsp_pos_x    = rsp_pos_x_ff;
   assign rsp_pos_y    = rsp_pos_y_ff;
   assign rsp_pressure = rsp_pressure_ff;

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps

module tb;
   import tcf_pkg::*;

   // Screen and divisor constants of the block as built here
   localparam int unsigned SCREEN_W  = SCREEN_WIDTH_DEF;
   localparam int unsigned SCREEN_H  = SCREEN_HEIGHT_DEF;
   localparam int unsigned X_DIVISOR = 15;
   localparam int unsigned Y_DIVISOR = 11;
   localparam int          RAW_MAX   = (1 << RAW_W) - 1;
   localparam int          CSR_SLOTS = 1 << CSR_IDX_W;

   localparam int LONG_HOLD_CYCLES = 60;  // receiver hold-off for the backpressure test
   localparam int DRAIN_CYCLES     = 4;   // settle margin after the last expected word is back
   localparam int WATCHDOG_NS      = 5_000_000;

   typedef struct packed {
      logic               touch_present;
      logic [RAW_W-1:0]   raw_x;
      logic [RAW_W-1:0]   raw_y;
      logic [PRESS_W-1:0] raw_pressure;
   } sample_type;

   typedef struct packed {
      logic               touched;
      logic [POS_X_W-1:0] pos_x;
      logic [POS_Y_W-1:0] pos_y;
      logic [PRESS_W-1:0] pressure;
   } position_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic                  req_touch_present;
   logic [RAW_W-1:0]      req_raw_x;
   logic [RAW_W-1:0]      req_raw_y;
   logic [PRESS_W-1:0]    req_raw_pressure;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic                  rsp_touched;
   logic [POS_X_W-1:0]    rsp_pos_x;
   logic [POS_Y_W-1:0]    rsp_pos_y;
   logic [PRESS_W-1:0]    rsp_pressure;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   // Shadow of the block: register copy and the held position
   cfg_type     cal_regs;
   int unsigned held_col;
   int unsigned held_row;

   position_type expected_positions[$];
   int unsigned error_count     = 0;
   int unsigned samples_sent    = 0;
   int unsigned positions_seen  = 0;
   int unsigned reg_writes      = 0;
   int unsigned input_stalls    = 0;

   // Idle control shared by the sender and the result-side ready driver
   bit          idle_on           = 1'b0;
   bit          long_hold_pending = 1'b0;
   int unsigned ready_stall_left  = 0;

   touch_coordinate_filter_core i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_touch_present (req_touch_present),
      .req_raw_x         (req_raw_x),
      .req_raw_y         (req_raw_y),
      .req_raw_pressure  (req_raw_pressure),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_touched       (rsp_touched),
      .rsp_pos_x         (rsp_pos_x),
      .rsp_pos_y         (rsp_pos_y),
      .rsp_pressure      (rsp_pressure),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Position predictor
   // ------------------------------------------------------------------

   // (top - sub) / divisor, zero when the difference is not positive,
   // saturated at the last pixel of the axis
   function automatic int unsigned calibrate_axis(int unsigned top, int unsigned sub,
                                                  int unsigned divisor, int unsigned span);
      int unsigned q;
      if (top <= sub)
         return 0;
      q = (top - sub) / divisor;
      return (q > span - 1) ? span - 1 : q;
   endfunction

   // Advances the held position by one sample and returns the result word
   function automatic position_type filter_sample(sample_type s);
      position_type r;
      int unsigned  base;
      int unsigned  nx;
      int unsigned  ny;
      int unsigned  moved;
      if (s.touch_present) begin
         base  = (s.raw_x <= cal_regs.x_split) ? 32'(cal_regs.x_offset_low)
                                                : 32'(cal_regs.x_offset_high);
         nx    = calibrate_axis(base, 32'(s.raw_x), X_DIVISOR, SCREEN_W);
         ny    = calibrate_axis(32'(s.raw_y), 32'(cal_regs.y_offset), Y_DIVISOR,
                                SCREEN_H);
         moved = ((nx > held_col) ? nx - held_col : held_col - nx)
               + ((ny > held_row) ? ny - held_row : held_row - ny);
         // deadband: equal to the threshold still holds
         if (moved > cal_regs.move_threshold) begin
            held_col = nx;
            held_row = ny;
         end
      end else begin
         held_col = 0;
         held_row = 0;
      end
      r.touched  = s.touch_present;
      r.pos_x    = held_col[POS_X_W-1:0];
      r.pos_y    = held_row[POS_Y_W-1:0];
      r.pressure = s.raw_pressure;
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Result side: ready driver and checker
   // ------------------------------------------------------------------

   // rsp_ready changes on the falling edge. Random stall bursts while idling
   // is on; a long hold-off when the backpressure test asks for one.
   always @(negedge clock) begin
      if (long_hold_pending) begin
         long_hold_pending = 1'b0;
         ready_stall_left  = LONG_HOLD_CYCLES;
      end else if (ready_stall_left == 0 && idle_on && $urandom_range(0, 5) == 0) begin
         ready_stall_left = $urandom_range(1, 10);
      end
      if (ready_stall_left > 0) begin
         rsp_ready = 1'b0;
         ready_stall_left--;
      end else begin
         rsp_ready = 1'b1;
      end
   end

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endtask

   // Every result word taken on a rising edge is matched with the oldest
   // expectation.
   always @(posedge clock) begin
      position_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_positions.size() == 0) begin
            $error("result word with nothing expected: touched=%0d x=%0d y=%0d p=%0d",
                   rsp_touched, rsp_pos_x, rsp_pos_y, rsp_pressure);
            error_count++;
         end else begin
            want = expected_positions.pop_front();
            positions_seen++;
            check_field("touched", 16'(want.touched), 16'(rsp_touched));
            check_field("pos_x", 16'(want.pos_x), 16'(rsp_pos_x));
            check_field("pos_y", 16'(want.pos_y), 16'(rsp_pos_y));
            check_field("pressure", 16'(want.pressure), 16'(rsp_pressure));
         end
      end
      if (!reset && req_valid && !req_ready)
         input_stalls++;
   end

   // ------------------------------------------------------------------
   // Drivers (called on a falling edge, return on a falling edge)
   // ------------------------------------------------------------------

   // Offers one sample word and holds it until the block takes it
   task automatic send_sample(input logic touch, input logic [RAW_W-1:0] x,
                              input logic [RAW_W-1:0] y, input logic [PRESS_W-1:0] p);
      sample_type s;
      s = '{touch_present: touch, raw_x: x, raw_y: y, raw_pressure: p};
      if (idle_on && $urandom_range(0, 4) == 0)
         repeat ($urandom_range(1, 10)) @(negedge clock);
      req_valid         = 1'b1;
      req_touch_present = s.touch_present;
      req_raw_x         = s.raw_x;
      req_raw_y         = s.raw_y;
      req_raw_pressure  = s.raw_pressure;
      do @(posedge clock); while (!req_ready);
      expected_positions.push_back(filter_sample(s));
      samples_sent++;
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   // Waits until every expected word is back and the pipe has settled
   task automatic wait_drained();
      while (expected_positions.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] data);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_X_SPLIT:        cal_regs.x_split        = data[RAW_W-1:0];
         REG_X_OFFSET_LOW:   cal_regs.x_offset_low   = data[OFFSET_W-1:0];
         REG_X_OFFSET_HIGH:  cal_regs.x_offset_high  = data[OFFSET_W-1:0];
         REG_Y_OFFSET:       cal_regs.y_offset       = data[RAW_W-1:0];
         REG_MOVE_THRESHOLD: cal_regs.move_threshold = data[MOVE_THR_W-1:0];
         default: ;  // unmapped index: block ignores it
      endcase
      reg_writes++;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic load_calibration(input logic [CSR_DATA_W-1:0] split,
                                   input logic [CSR_DATA_W-1:0] off_low,
                                   input logic [CSR_DATA_W-1:0] off_high,
                                   input logic [CSR_DATA_W-1:0] y_off,
                                   input logic [CSR_DATA_W-1:0] threshold);
      wait_drained();
      write_register(REG_X_SPLIT, split);
      write_register(REG_X_OFFSET_LOW, off_low);
      write_register(REG_X_OFFSET_HIGH, off_high);
      write_register(REG_Y_OFFSET, y_off);
      write_register(REG_MOVE_THRESHOLD, threshold);
   endtask

   // Random walk of a raw coordinate, kept inside the 12-bit range
   function automatic logic [RAW_W-1:0] drift(input logic [RAW_W-1:0] v, input int span);
      int moved;
      moved = int'(v) + int'($urandom_range(0, 2 * span)) - span;
      if (moved < 0)
         moved = 0;
      if (moved > RAW_MAX)
         moved = RAW_MAX;
      return moved[RAW_W-1:0];
   endfunction

   // Mostly finger-down strokes: a touched run that wanders by small,
   // medium or big steps, usually followed by a lift. Some pure noise words.
   task automatic run_touch_traffic(input int unsigned count);
      int unsigned      done;
      int unsigned      stroke_len;
      int unsigned      lifts;
      int               span;
      logic [RAW_W-1:0] x;
      logic [RAW_W-1:0] y;
      done = 0;
      while (done < count) begin
         if ($urandom_range(0, 6) == 0) begin
            send_sample(1'($urandom_range(0, 1)), RAW_W'($urandom), RAW_W'($urandom),
                        PRESS_W'($urandom));
            done++;
         end else begin
            stroke_len = $urandom_range(1, 24);
            case ($urandom_range(0, 2))
               0:       span = 8;
               1:       span = 45;
               default: span = 300;
            endcase
            x = RAW_W'($urandom);
            y = RAW_W'($urandom);
            for (int k = 0; k < stroke_len && done < count; k++) begin
               x = drift(x, span);
               y = drift(y, span);
               send_sample(1'b1, x, y, PRESS_W'($urandom));
               done++;
            end
            lifts = $urandom_range(0, 3);
            for (int k = 0; k < lifts && done < count; k++) begin
               send_sample(1'b0, RAW_W'($urandom), RAW_W'($urandom), PRESS_W'($urandom));
               done++;
            end
         end
      end
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Reset calibration; field extremes and each corner of the arithmetic
   task automatic test_directed_corners();
      send_sample(1'b0, 12'd0, 12'd0, 8'd0);           // no touch, all zero
      send_sample(1'b1, 12'd0, 12'hFFF, 8'hFF);        // both axes saturate
      send_sample(1'b1, 12'hFFF, 12'd0, 8'h80);        // both differences negative
      send_sample(1'b1, 12'd3000, 12'd360, 8'h55);     // X on the split, Y on its offset
      send_sample(1'b1, 12'd3001, 12'd361, 8'hAA);     // just above split, move == threshold
      send_sample(1'b1, 12'd3800, 12'd371, 8'd1);      // X difference exactly zero
      send_sample(1'b1, 12'd3799, 12'd372, 8'hFE);     // quotients round down to 0 and 1
      send_sample(1'b1, 12'hAAA, 12'h555, 8'h7F);
      send_sample(1'b1, 12'h555, 12'hAAA, 8'h80);
      send_sample(1'b0, 12'hFFF, 12'hFFF, 8'hFF);      // lift clears the position
      send_sample(1'b1, 12'd2900, 12'd900, 8'd10);     // lands at (64, 49)
      send_sample(1'b1, 12'd2915, 12'd900, 8'd11);     // one pixel: held
      send_sample(1'b1, 12'd2900, 12'd955, 8'd12);     // five pixels: still held
      send_sample(1'b1, 12'd2900, 12'd966, 8'd13);     // six pixels: moves
      send_sample(1'b1, 12'd0, 12'd0, 8'd14);
      send_sample(1'b0, 12'd1234, 12'd3210, 8'd15);
   endtask

   // Writes to indexes past the register list must change nothing
   task automatic test_unmapped_writes();
      wait_drained();
      for (int idx = REG_MOVE_THRESHOLD + 1; idx < CSR_SLOTS; idx++)
         write_register(CSR_IDX_W'(idx), CSR_DATA_W'($urandom));
      run_touch_traffic(50);
   endtask

   // Calibration at the ends of every register's range
   task automatic test_calibration_extremes();
      // all X below the split; low offset at maximum, zero Y offset, no deadband
      load_calibration(13'h1FFF, 13'h1FFF, 13'd0, 13'd0, 13'd0);
      run_touch_traffic(150);
      // split at zero, Y offset at maximum, deadband at maximum
      load_calibration(13'd0, 13'd0, 13'h1FFF, 13'h0FFF, 13'h03FF);
      run_touch_traffic(150);
   endtask

   // Random calibrations; unused high data bits are set at random too
   task automatic test_random_calibration(input int unsigned phases);
      logic [CSR_DATA_W-1:0] off_low;
      logic [CSR_DATA_W-1:0] off_high;
      for (int n = 0; n < phases; n++) begin
         if ($urandom_range(0, 1)) begin
            off_low  = CSR_DATA_W'($urandom_range(2500, 5500));
            off_high = CSR_DATA_W'($urandom_range(2500, 5500));
         end else begin
            off_low  = CSR_DATA_W'($urandom);
            off_high = CSR_DATA_W'($urandom);
         end
         load_calibration(CSR_DATA_W'($urandom), off_low, off_high,
                          CSR_DATA_W'($urandom_range(0, 800)
                                      | ($urandom_range(0, 1) << RAW_W)),
                          CSR_DATA_W'($urandom_range(0, 12)
                                      | ($urandom_range(0, 7) << MOVE_THR_W)));
         run_touch_traffic(150);
      end
   endtask

   // Receiver holds off for a long stretch while words keep coming, so the
   // block fills and must drop req_ready.
   task automatic test_output_backpressure();
      wait_drained();
      idle_on           = 1'b0;
      long_hold_pending = 1'b1;
      run_touch_traffic(40);
      idle_on = 1'b1;
   endtask

   // Final stretch at reset calibration with no gaps on either side
   task automatic test_steady_stream();
      load_calibration(CSR_DATA_W'(X_SPLIT_RST), CSR_DATA_W'(X_OFFSET_LOW_RST),
                       CSR_DATA_W'(X_OFFSET_HIGH_RST), CSR_DATA_W'(Y_OFFSET_RST),
                       CSR_DATA_W'(MOVE_THRESHOLD_RST));
      idle_on = 1'b0;
      run_touch_traffic(250);
   endtask

   initial begin
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_touch_present = 1'b0;
      req_raw_x         = '0;
      req_raw_y         = '0;
      req_raw_pressure  = '0;
      rsp_ready         = 1'b0;
      csr_valid         = 1'b0;
      csr_index         = '0;
      csr_data          = '0;
      cal_regs = '{x_split: X_SPLIT_RST, x_offset_low: X_OFFSET_LOW_RST,
                   x_offset_high: X_OFFSET_HIGH_RST, y_offset: Y_OFFSET_RST,
                   move_threshold: MOVE_THRESHOLD_RST};
      held_col = 0;
      held_row = 0;
      // reset held from time zero, released on a falling edge
      repeat (2) @(negedge clock);
      reset = 1'b0;

      test_directed_corners();
      idle_on = 1'b1;
      test_unmapped_writes();
      test_calibration_extremes();
      test_random_calibration(4);
      test_output_backpressure();
      test_steady_stream();
      wait_drained();

      $display("%0d samples sent, %0d result words checked, %0d register writes,",
               samples_sent, positions_seen, reg_writes);
      $display("input stalled on %0d cycles across reset, extreme and random calibrations",
               input_stalls);
      if (error_count == 0 && expected_positions.size() == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #WATCHDOG_NS;
      $error("timeout with %0d result words outstanding", expected_positions.size());
      $display("tb failed");
      $finish;
   end

endmodule
